// ===== rtl/sdl_pkg.sv =====
// sdl_pkg: shared types and constants of the log deframer.
// Used by every module in rtl but sdl_ram; no dependencies.
package sdl_pkg;

   localparam int TYPE_COUNT = 256;
   localparam int TYPE_AW    = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
   localparam logic [8:0] TYPE_LIMIT = 9'(TYPE_COUNT);
   localparam logic [7:0] HEADER_LEN = 8'd3;

   localparam logic [7:0] RST_SYNC_FIRST  = 8'd163;
   localparam logic [7:0] RST_SYNC_SECOND = 8'd149;
   localparam logic [7:0] RST_FMT_TYPE    = 8'd128;
   localparam logic [7:0] RST_FMT_LEN     = 8'd89;

   typedef enum logic [1:0] {
      CSR_SYNC_FIRST  = 2'd0,
      CSR_SYNC_SECOND = 2'd1,
      CSR_FMT_TYPE    = 2'd2,
      CSR_FMT_LEN     = 2'd3
   } sdl_csr_idx_type;

   typedef enum logic [1:0] {
      PH_HUNT1   = 2'd0,
      PH_HUNT2   = 2'd1,
      PH_TYPE    = 2'd2,
      PH_PAYLOAD = 2'd3
   } sdl_phase_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } sdl_req_type;

   typedef struct packed {
      logic [7:0] record_type;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic       first_of_record;
      logic       last_of_record;
      logic       empty_record;
   } sdl_rsp_type;

   typedef struct packed {
      logic [7:0] sync_first;
      logic [7:0] sync_second;
      logic [7:0] fmt_type;
      logic [7:0] fmt_len;
   } sdl_cfg_type;

   typedef struct packed {
      logic               en;
      logic [TYPE_AW-1:0] addr;
      logic [7:0]         data;
   } sdl_tbl_wr_type;

endpackage

// ===== rtl/self_describing_log_deframer_core.sv =====
// self_describing_log_deframer_core: top level of the log record deframer.
// An accepted byte is held in the input stage and moves on to the output register when that
// register is free (input stage, output register).
// Throughput: one byte per cycle while rsp_stall is low; the length RAM is read once per byte as it is accepted.
// Reset: synchronous; clears parse state and all 256 length-known marks at once, no sweep.
// Length RAM contents are undefined until written by a format record.
// Depends on sdl_pkg, sdl_ram, sdl_csr, sdl_parser.
module self_describing_log_deframer_core
   import sdl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  sdl_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output sdl_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   sdl_cfg_type    cfg;
   sdl_tbl_wr_type tbl_wr;
   sdl_req_type    s1_data_ff;
   logic           s1_valid_ff, s1_valid_in;
   logic           rsp_valid_ff, rsp_valid_in;
   sdl_rsp_type    rsp_data_ff;
   logic           out_free;
   logic           fire;
   logic           req_acc;
   logic [7:0]     rd_data;
   logic           res_valid;
   sdl_rsp_type    res;

   assign csr_ready = 1'b1;

   sdl_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (sdl_csr_idx_type'(csr_index)),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !fire;
   assign req_acc   = req_valid && !req_stall;

   sdl_ram #(
      .WIDTH (8),
      .DEPTH (TYPE_COUNT)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (tbl_wr.en),
      .wr_addr (tbl_wr.addr),
      .wr_data (tbl_wr.data),
      .rd_en   (req_acc),
      .rd_addr (req_data.byte_value[TYPE_AW-1:0]),
      .rd_data (rd_data)
   );

   sdl_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .rd_issue  (req_acc),
      .rd_addr   (req_data.byte_value[TYPE_AW-1:0]),
      .rd_data   (rd_data),
      .fire      (fire),
      .word      (s1_data_ff),
      .tbl_wr    (tbl_wr),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      s1_valid_in = req_acc ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
      if (fire) begin
         rsp_valid_in = res_valid;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_data_ff <= req_data;
      end
      if (fire && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/sdl_ram.sv =====
// sdl_ram: generic single write port, single read port RAM.
// Read data is registered; a read of the address being written returns old data.
module sdl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                    wr_data,
   input  logic                                rd_en,
   input  logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sdl_csr.sv =====
// sdl_csr: configuration registers (sync bytes, format record type and length).
// Depends on sdl_pkg.
module sdl_csr
   import sdl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            wr_en,
   input  sdl_csr_idx_type wr_index,
   input  logic [7:0]      wr_data,
   output sdl_cfg_type     cfg
);

   sdl_cfg_type cfg_ff;
   sdl_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_SYNC_FIRST:  cfg_in.sync_first  = wr_data;
            CSR_SYNC_SECOND: cfg_in.sync_second = wr_data;
            CSR_FMT_TYPE:    cfg_in.fmt_type    = wr_data;
            CSR_FMT_LEN:     cfg_in.fmt_len     = wr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= RST_SYNC_FIRST;
         cfg_ff.sync_second <= RST_SYNC_SECOND;
         cfg_ff.fmt_type    <= RST_FMT_TYPE;
         cfg_ff.fmt_len     <= RST_FMT_LEN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/sdl_parser.sv =====
// sdl_parser: record parse state machine, length-known marks and table write/forward logic.
// Depends on sdl_pkg; reads the registered length RAM output for the byte held in the input stage.
module sdl_parser
   import sdl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  sdl_cfg_type        cfg,
   input  logic               rd_issue,
   input  logic [TYPE_AW-1:0] rd_addr,
   input  logic [7:0]         rd_data,
   input  logic               fire,
   input  sdl_req_type        word,
   output sdl_tbl_wr_type     tbl_wr,
   output logic               res_valid,
   output sdl_rsp_type        res
);

   sdl_phase_type       phase_ff, phase_in;
   logic [7:0]          cur_type_ff, cur_type_in;
   logic [7:0]          left_ff, left_in;
   logic [7:0]          pos_ff, pos_in;
   logic [7:0]          latch_ff, latch_in;
   logic [TYPE_COUNT-1:0] known_ff, known_in;
   logic                fwd_hit_ff;
   logic [7:0]          fwd_data_ff;

   logic       is_fmt;
   logic       in_range;
   logic       latch_ok;
   logic [7:0] tbl_len;
   logic [7:0] total;
   logic [7:0] plen;
   logic       known;
   logic       first;
   logic       last;

   always_comb begin
      is_fmt   = (word.byte_value == cfg.fmt_type);
      in_range = ({1'b0, word.byte_value} < TYPE_LIMIT);
      latch_ok = ({1'b0, latch_ff} < TYPE_LIMIT);
      tbl_len  = fwd_hit_ff ? fwd_data_ff : rd_data;
      total    = is_fmt ? cfg.fmt_len : tbl_len;
      plen     = (total < HEADER_LEN) ? 8'd0 : total - HEADER_LEN;
      known    = is_fmt || (in_range && known_ff[word.byte_value[TYPE_AW-1:0]]);
      first    = (pos_ff == 8'd0);
      last     = (left_ff <= 8'd1);

      phase_in    = phase_ff;
      cur_type_in = cur_type_ff;
      left_in     = left_ff;
      pos_in      = pos_ff;
      latch_in    = latch_ff;
      known_in    = known_ff;
      tbl_wr      = '0;
      res_valid   = 1'b0;
      res         = '0;

      if (fire) begin
         unique case (phase_ff)
            PH_HUNT1: begin
               if (word.byte_value == cfg.sync_first) begin
                  phase_in = PH_HUNT2;
               end
            end
            PH_HUNT2: begin
               if (word.byte_value == cfg.sync_second) begin
                  phase_in = PH_TYPE;
               end else if (word.byte_value != cfg.sync_first) begin
                  phase_in = PH_HUNT1;
               end
            end
            PH_TYPE: begin
               cur_type_in = word.byte_value;
               if (!known) begin
                  phase_in = PH_HUNT1;
               end else if (plen == 8'd0) begin
                  res_valid           = 1'b1;
                  res.record_type     = word.byte_value;
                  res.first_of_record = 1'b1;
                  res.last_of_record  = 1'b1;
                  res.empty_record    = 1'b1;
                  phase_in            = PH_HUNT1;
               end else begin
                  left_in  = plen;
                  pos_in   = 8'd0;
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               if (cur_type_ff == cfg.fmt_type) begin
                  if (pos_ff == 8'd0) begin
                     latch_in = word.byte_value;
                  end else if (pos_ff == 8'd1 && latch_ok) begin
                     tbl_wr.en   = 1'b1;
                     tbl_wr.addr = latch_ff[TYPE_AW-1:0];
                     tbl_wr.data = word.byte_value;
                     known_in[latch_ff[TYPE_AW-1:0]] = 1'b1;
                  end
               end
               res_valid           = 1'b1;
               res.record_type     = cur_type_ff;
               res.payload_byte    = word.byte_value;
               res.payload_index   = pos_ff;
               res.first_of_record = first;
               res.last_of_record  = last;
               if (last) begin
                  left_in  = 8'd0;
                  phase_in = PH_HUNT1;
               end else begin
                  left_in = left_ff - 8'd1;
                  pos_in  = pos_ff + 8'd1;
               end
            end
            default: phase_in = PH_HUNT1;
         endcase
         if (word.last_byte) begin
            phase_in = PH_HUNT1;
            left_in  = 8'd0;
            pos_in   = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT1;
         cur_type_ff <= 8'd0;
         left_ff     <= 8'd0;
         pos_ff      <= 8'd0;
         latch_ff    <= 8'd0;
         known_ff    <= '0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         cur_type_ff <= cur_type_in;
         left_ff     <= left_in;
         pos_ff      <= pos_in;
         latch_ff    <= latch_in;
         known_ff    <= known_in;
         if (rd_issue) begin
            // RAM returns old data when the same entry is written this cycle
            fwd_hit_ff <= tbl_wr.en && (tbl_wr.addr == rd_addr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_issue) begin
         fwd_data_ff <= tbl_wr.data;
      end
   end

   a_wr_in_payload: assert property (@(posedge clock) disable iff (reset)
      tbl_wr.en |-> (phase_ff == PH_PAYLOAD && fire))
      else $error("table write outside payload phase");

   a_empty_marks: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.empty_record) |-> (res.first_of_record && res.last_of_record
                                           && res.payload_byte == 8'd0))
      else $error("empty record result without first/last marks");

   a_known_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (known_ff == '0))
      else $error("length-known marks not cleared by reset");

   a_fwd_capture: assert property (@(posedge clock) disable iff (reset)
      (rd_issue && tbl_wr.en && tbl_wr.addr == rd_addr) |=> fwd_hit_ff)
      else $error("same-entry write not forwarded");

   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (left_ff != 8'd0))
      else $error("payload phase with no bytes left");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for self_describing_log_deframer_core.
// Drives bytes through the deframer, predicts every output word, compares fields.
// Depends on sdl_pkg and the RTL under rtl/.
module testbench;
   import sdl_pkg::*;

   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_WORDS  = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   sdl_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   sdl_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   // predictor state
   sdl_cfg_type   cfg_shadow;
   sdl_phase_type hunt_phase;
   logic [7:0]    rec_type;
   logic [7:0]    remaining;
   logic [7:0]    position;
   logic [7:0]    described;
   logic [7:0]    length_of [TYPE_COUNT];
   logic          length_valid [TYPE_COUNT];
   sdl_rsp_type   awaited_words [$];

   int cycle_count    = 0;
   int mismatch_count = 0;
   int words_sent     = 0;
   int sender_bursty  = 1;
   int burst_left     = 0;
   int hold_request   = 0;
   int hold_left      = 0;
   int stall_span     = 0;
   int stall_pct      = 0;

   self_describing_log_deframer_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [7:0] body_length(input logic [7:0] total);
      return (total < HEADER_LEN) ? 8'd0 : total - HEADER_LEN;
   endfunction

   function automatic void model_reset();
      cfg_shadow = {RST_SYNC_FIRST, RST_SYNC_SECOND, RST_FMT_TYPE, RST_FMT_LEN};
      hunt_phase = PH_HUNT1;
      rec_type   = '0;
      remaining  = '0;
      position   = '0;
      described  = '0;
      for (int i = 0; i < TYPE_COUNT; i++) begin
         length_of[i]    = '0;
         length_valid[i] = 1'b0;
      end
   endfunction

   // advances the deframe state by one byte and queues any word it produces
   function automatic void deframe_byte(input sdl_req_type w);
      logic [7:0]  plen;
      logic        known;
      logic        first;
      logic        fin;
      sdl_rsp_type r;
      plen  = '0;
      known = 1'b0;
      case (hunt_phase)
         PH_HUNT1: begin
            if (w.byte_value == cfg_shadow.sync_first) hunt_phase = PH_HUNT2;
         end
         PH_HUNT2: begin
            if (w.byte_value == cfg_shadow.sync_second) hunt_phase = PH_TYPE;
            else if (w.byte_value != cfg_shadow.sync_first) hunt_phase = PH_HUNT1;
         end
         PH_TYPE: begin
            rec_type = w.byte_value;
            if (w.byte_value == cfg_shadow.fmt_type) begin
               known = 1'b1;
               plen  = body_length(cfg_shadow.fmt_len);
            end else if (int'(w.byte_value) < TYPE_COUNT && length_valid[w.byte_value]) begin
               known = 1'b1;
               plen  = body_length(length_of[w.byte_value]);
            end
            if (!known) begin
               hunt_phase = PH_HUNT1;
            end else if (plen == 0) begin
               r = {rec_type, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1};
               awaited_words.push_back(r);
               hunt_phase = PH_HUNT1;
            end else begin
               remaining  = plen;
               position   = '0;
               hunt_phase = PH_PAYLOAD;
            end
         end
         default: begin
            first = (position == 0);
            fin   = (remaining <= 1);
            if (rec_type == cfg_shadow.fmt_type) begin
               if (position == 0) begin
                  described = w.byte_value;
               end else if (position == 1 && int'(described) < TYPE_COUNT) begin
                  length_of[described]    = w.byte_value;
                  length_valid[described] = 1'b1;
               end
            end
            r = {rec_type, w.byte_value, position, first, fin, 1'b0};
            awaited_words.push_back(r);
            if (fin) begin
               remaining  = '0;
               hunt_phase = PH_HUNT1;
            end else begin
               remaining = remaining - 8'd1;
               position  = position + 8'd1;
            end
         end
      endcase
      if (w.last_byte) begin
         hunt_phase = PH_HUNT1;
         remaining  = '0;
         position   = '0;
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t: %s got %0h want %0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin : check_rsp
      sdl_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_words.size() == 0) begin
            report_mismatch("unexpected word",
                            {8'h00, rsp_data.record_type, rsp_data.payload_byte,
                             rsp_data.payload_index}, 32'h0);
         end else begin
            want = awaited_words.pop_front();
            if (rsp_data.record_type !== want.record_type)
               report_mismatch("record_type", 32'(rsp_data.record_type),
                               32'(want.record_type));
            if (rsp_data.payload_byte !== want.payload_byte)
               report_mismatch("payload_byte", 32'(rsp_data.payload_byte),
                               32'(want.payload_byte));
            if (rsp_data.payload_index !== want.payload_index)
               report_mismatch("payload_index", 32'(rsp_data.payload_index),
                               32'(want.payload_index));
            if (rsp_data.first_of_record !== want.first_of_record)
               report_mismatch("first_of_record", 32'(rsp_data.first_of_record),
                               32'(want.first_of_record));
            if (rsp_data.last_of_record !== want.last_of_record)
               report_mismatch("last_of_record", 32'(rsp_data.last_of_record),
                               32'(want.last_of_record));
            if (rsp_data.empty_record !== want.empty_record)
               report_mismatch("empty_record", 32'(rsp_data.empty_record),
                               32'(want.empty_record));
         end
      end
   end

   // receiver: stall rate changes per stretch, long hold-offs on request
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (stall_span == 0) begin
         stall_span = $urandom_range(16, 96);
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 85;
         endcase
      end
      stall_span--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic send_word(input logic [7:0] value, input logic is_last);
      int          gap;
      sdl_req_type w;
      gap = 0;
      w   = {value, is_last};
      if (sender_bursty != 0) begin
         if (burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      deframe_byte(w);
      words_sent++;
   endtask

   task automatic await_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input sdl_csr_idx_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SYNC_FIRST:  cfg_shadow.sync_first  = value;
         CSR_SYNC_SECOND: cfg_shadow.sync_second = value;
         CSR_FMT_TYPE:    cfg_shadow.fmt_type    = value;
         default:         cfg_shadow.fmt_len     = value;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_config(input logic [7:0] sf, input logic [7:0] ss,
                                 input logic [7:0] ft, input logic [7:0] fl);
      write_csr(CSR_SYNC_FIRST, sf);
      write_csr(CSR_SYNC_SECOND, ss);
      write_csr(CSR_FMT_TYPE, ft);
      write_csr(CSR_FMT_LEN, fl);
   endtask

   // header, type and as many payload bytes as the current length says;
   // cut puts last_byte on that byte of the record and drops the rest
   task automatic send_record(input logic [7:0] rtype, input logic [7:0] p0,
                              input logic [7:0] p1, input int cut);
      int body;
      if (rtype == cfg_shadow.fmt_type) body = int'(body_length(cfg_shadow.fmt_len));
      else if (int'(rtype) < TYPE_COUNT && length_valid[rtype])
         body = int'(body_length(length_of[rtype]));
      else body = 0;
      send_word(cfg_shadow.sync_first, cut == 0);
      send_word(cfg_shadow.sync_second, cut == 1);
      send_word(rtype, cut == 2);
      for (int i = 0; i < body && (cut < 0 || i + 3 <= cut); i++)
         send_word((i == 0) ? p0 : (i == 1) ? p1 : 8'($urandom),
                   (cut == i + 3) || ($urandom_range(0, 199) == 0));
   endtask

   task automatic test_reset_values();
      send_record(RST_FMT_TYPE, 8'h07, 8'h04, -1);
      send_record(8'h07, 8'h3C, 8'h00, -1);
      await_idle();
   endtask

   task automatic test_directed_cases();
      logic [7:0] ft;
      write_csr(CSR_FMT_LEN, 8'd5);
      ft = cfg_shadow.fmt_type;
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      // repeated first header byte ahead of a format word pair
      send_word(cfg_shadow.sync_first, 1'b0);
      send_record(ft, 8'h07, 8'h04, -1);
      send_record(8'h07, 8'hFF, 8'h00, -1);
      // unknown type, hunt resumes on the very next byte
      send_record(8'h09, 8'h00, 8'h00, -1);
      send_record(8'h07, 8'h00, 8'h00, -1);
      // total length under the header size
      send_record(ft, 8'h09, 8'h02, -1);
      send_record(8'h09, 8'h00, 8'h00, -1);
      // partial format record dropped by last_byte
      send_record(ft, 8'h0A, 8'h06, 3);
      send_record(8'h0A, 8'h11, 8'h22, -1);
      send_record(8'h07, 8'h5A, 8'h00, 2);
      send_record(8'h07, 8'hA5, 8'h00, -1);
      await_idle();
   endtask

   task automatic test_config_extremes();
      program_config(8'h00, 8'hFF, 8'h00, 8'd3);
      send_record(8'h00, 8'h01, 8'h02, -1);
      send_record(8'h07, 8'h80, 8'h00, -1);
      send_word(8'h00, 1'b0);
      send_record(8'h07, 8'h01, 8'h00, -1);
      await_idle();
      // equal header bytes, format record too short to write the table
      program_config(8'h55, 8'h55, 8'h10, 8'd4);
      send_record(8'h10, 8'h20, 8'h09, -1);
      send_record(8'h20, 8'h01, 8'h02, -1);
      send_word(8'h55, 1'b0);
      send_record(8'h07, 8'h66, 8'h00, -1);
      send_record(8'h07, 8'h99, 8'h00, -1);
      await_idle();
      program_config(8'hFF, 8'h00, 8'hFF, 8'd255);
      send_record(8'hFF, 8'h20, 8'h08, -1);
      send_record(8'h20, 8'hFF, 8'h00, -1);
      await_idle();
   endtask

   task automatic test_output_backpressure();
      program_config(RST_SYNC_FIRST, RST_SYNC_SECOND, RST_FMT_TYPE, 8'd6);
      sender_bursty = 0;
      send_record(RST_FMT_TYPE, 8'h03, 8'd40, -1);
      hold_request = 150;
      repeat (3) send_record(8'h03, 8'($urandom), 8'($urandom), -1);
      await_idle();
      sender_bursty = 1;
   endtask

   task automatic random_record();
      logic [7:0] t;
      logic [7:0] teach;
      int         pick;
      int         cut;
      int         tries;
      pick  = $urandom_range(0, 99);
      cut   = (pick >= 92) ? $urandom_range(0, 6) : -1;
      t     = 8'($urandom_range(0, 15));
      tries = 0;
      while (!length_valid[t] && tries < 8) begin
         t = 8'($urandom_range(0, 15));
         tries++;
      end
      case ($urandom_range(0, 49))
         0:              teach = 8'd255;
         1, 2, 3, 4, 5:  teach = 8'($urandom_range(0, 2));
         6, 7, 8, 9, 10: teach = 8'($urandom_range(21, 70));
         default:        teach = 8'($urandom_range(3, 20));
      endcase
      if (pick < 55 || (pick >= 92 && pick < 96)) begin
         send_record(t, 8'($urandom), 8'($urandom), cut);
      end else if (pick < 75 || pick >= 96) begin
         send_record(cfg_shadow.fmt_type,
                     ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 15))
                                                 : 8'($urandom),
                     teach, cut);
      end else if (pick < 83) begin
         send_record(8'($urandom), 8'($urandom), 8'($urandom), -1);
      end else begin
         repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 3))
               0: send_word(cfg_shadow.sync_first, $urandom_range(0, 19) == 0);
               1: send_word(cfg_shadow.sync_second, $urandom_range(0, 19) == 0);
               default: send_word(8'($urandom), $urandom_range(0, 19) == 0);
            endcase
         end
      end
   endtask

   task automatic test_random_stream();
      int start;
      logic [7:0] fl;
      for (int ph = 0; ph < 4; ph++) begin
         await_idle();
         if (ph > 0) begin
            case ($urandom_range(0, 7))
               0: fl = 8'($urandom_range(3, 4));
               7: fl = 8'($urandom_range(30, 60));
               default: fl = 8'($urandom_range(5, 12));
            endcase
            program_config(8'($urandom), 8'($urandom),
                           ($urandom_range(0, 1) != 0) ? RST_FMT_TYPE : 8'($urandom), fl);
         end
         start = words_sent;
         while (words_sent - start < RANDOM_WORDS / 4) random_record();
      end
   endtask

   initial begin
      model_reset();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_directed_cases();
      test_config_extremes();
      test_output_backpressure();
      test_random_stream();
      await_idle();
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
